// File: design/mxt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_pkg
// shared constants and types for the maximum subarray xor trie core
// ----------------------------------------------------------------------------
package mxt_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_SLOTS = 65536;

   localparam int VALUE_W = 31;
   localparam int OUT_W   = 31;
   localparam int LINK_W  = $clog2(NODE_SLOTS);
   localparam int CNT_W   = $clog2(NODE_SLOTS + 1);
   localparam int LVL_W   = $clog2(KEY_BITS);
   localparam int NODE_W  = 2 * LINK_W;

   typedef logic [LINK_W-1:0] link_type;

   // result of one trie level decision
   typedef struct packed {
      logic     hit;
      logic     took_opp;
      link_type next;
   } step_type;

endpackage

// File: design/mxt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mxt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/mxt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_step
// one trie level: picks the child link to follow for insert or query walks
// ----------------------------------------------------------------------------
module mxt_step import mxt_pkg::*; (
   input  link_type link_zero,
   input  link_type link_one,
   input  logic     key_bit,
   input  logic     seek_opp,
   output step_type result
);

   link_type same_link;
   link_type opp_link;
   link_type first_link;

   always_comb begin
      same_link  = key_bit ? link_one : link_zero;
      opp_link   = key_bit ? link_zero : link_one;
      first_link = seek_opp ? opp_link : same_link;
      result     = '0;
      if (first_link != '0) begin
         result.hit      = 1'b1;
         result.took_opp = seek_opp;
         result.next     = first_link;
      end else if (seek_opp && same_link != '0) begin
         // no opposite child, fall back to the matching one
         result.hit  = 1'b1;
         result.next = same_link;
      end
   end

endmodule

// File: design/max_xor_subarray_trie_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_xor_subarray_trie_core
// largest xor of any contiguous run over a stream of unsigned values
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one value per transaction; req_start_new clears the trie,
//   running prefix, best result and full flag before that value is used.
//   each accepted request yields exactly one rsp_* transaction holding the
//   best run xor so far and a sticky flag set when a node insert was skipped.
// timing:
//   the node store is one ram with a single read port, so the trie levels
//   are walked one after another. a request runs the insert walk, then one
//   allocation step per new node when the insert allocates, then the query
//   walk down the KEY_BITS levels and last the load of the output register.
//   req_stall is high from acceptance until the result is loaded into the
//   output register.
// reset:
//   synchronous reset empties the trie (root links held in flops), clears
//   prefix, best and flag; the node ram needs no clearing pass.
// back pressure:
//   the result waits in the output register while rsp_stall is high; a new
//   request is taken meanwhile, but its result waits until the register frees.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie_core import mxt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_start_new,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [OUT_W-1:0]   rsp_best_xor,
   output logic               rsp_store_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_ALLOC,
      ST_QRY,
      ST_DONE
   } state_type;

   localparam int CHK_W = CNT_W + 1;

   state_type           state_ff,    state_in;
   logic [LVL_W-1:0]    lvl_ff,      lvl_in;
   link_type            node_ff,     node_in;
   logic                at_root_ff,  at_root_in;
   link_type            root_zero_ff, root_zero_in;
   link_type            root_one_ff,  root_one_in;
   logic [CNT_W-1:0]    count_ff,    count_in;
   logic [KEY_BITS-1:0] prefix_ff,   prefix_in;
   logic [KEY_BITS-1:0] val_ff,      val_in;
   logic [KEY_BITS-1:0] best_ff,     best_in;
   logic [KEY_BITS-1:0] acc_ff,      acc_in;
   logic                ovf_ff,      ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_best_ff,  rsp_best_in;
   logic                rsp_full_ff,  rsp_full_in;

   logic                ram_wr_en;
   link_type            ram_wr_addr;
   logic [NODE_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   link_type            ram_rd_addr;
   logic [NODE_W-1:0]   ram_rd_data;

   link_type            cur_zero;
   link_type            cur_one;
   logic                key_bit;
   logic                low_bit;
   logic [LVL_W-1:0]    lvl_dec;
   step_type            step;
   logic [CHK_W-1:0]    need_total;
   link_type            new_link;
   link_type            chain_link;
   logic [63:0]         value_wide;
   logic [63:0]         best_wide;
   logic [KEY_BITS-1:0] best_new;
   logic                rsp_free;

   mxt_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_SLOTS)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // root links live in flops, every other node comes from the ram
   assign cur_zero = at_root_ff ? root_zero_ff : ram_rd_data[LINK_W-1:0];
   assign cur_one  = at_root_ff ? root_one_ff  : ram_rd_data[NODE_W-1:LINK_W];
   assign key_bit  = prefix_ff[lvl_ff];
   assign lvl_dec  = lvl_ff - 1'b1;

   mxt_step u_step (
      .link_zero (cur_zero),
      .link_one  (cur_one),
      .key_bit   (key_bit),
      .seek_opp  (state_ff == ST_QRY),
      .result    (step)
   );

   assign value_wide = 64'(req_value);
   assign best_wide  = 64'(best_new);
   assign new_link   = count_ff[LINK_W-1:0];
   assign chain_link = LINK_W'(count_ff + 1'b1);
   assign need_total = CHK_W'(count_ff) + CHK_W'(lvl_ff) + 1'b1;
   assign best_new   = (acc_ff > best_ff) ? acc_ff : best_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      at_root_in   = at_root_ff;
      root_zero_in = root_zero_ff;
      root_one_in  = root_one_ff;
      count_in     = count_ff;
      prefix_in    = prefix_ff;
      val_in       = val_ff;
      best_in      = best_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_best_in  = rsp_best_ff;
      rsp_full_in  = rsp_full_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = node_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = step.next;
      low_bit      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in     = value_wide[KEY_BITS-1:0];
               lvl_in     = LVL_W'(KEY_BITS - 1);
               at_root_in = 1'b1;
               node_in    = '0;
               state_in   = ST_INS;
               if (req_start_new) begin
                  root_zero_in = '0;
                  root_one_in  = '0;
                  count_in     = CNT_W'(1);
                  prefix_in    = '0;
                  best_in      = '0;
                  ovf_in       = 1'b0;
               end
            end
         end

         ST_INS: begin
            if (step.hit) begin
               if (lvl_ff == '0) begin
                  // key already stored
                  prefix_in  = prefix_ff ^ val_ff;
                  lvl_in     = LVL_W'(KEY_BITS - 1);
                  at_root_in = 1'b1;
                  acc_in     = '0;
                  state_in   = ST_QRY;
               end else begin
                  ram_rd_en  = 1'b1;
                  node_in    = step.next;
                  at_root_in = 1'b0;
                  lvl_in     = lvl_dec;
               end
            end else if (need_total > CHK_W'(NODE_SLOTS)) begin
               ovf_in     = 1'b1;
               prefix_in  = prefix_ff ^ val_ff;
               lvl_in     = LVL_W'(KEY_BITS - 1);
               at_root_in = 1'b1;
               acc_in     = '0;
               state_in   = ST_QRY;
            end else begin
               // hook the first new node onto the parent
               if (at_root_ff) begin
                  if (key_bit) begin
                     root_one_in = new_link;
                  end else begin
                     root_zero_in = new_link;
                  end
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = node_ff;
                  ram_wr_data = key_bit ? {new_link, cur_zero} : {cur_one, new_link};
               end
               state_in = ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            // node at this level links to the next one, the leaf has no children
            ram_wr_en   = 1'b1;
            ram_wr_addr = new_link;
            if (lvl_ff != '0) begin
               low_bit     = prefix_ff[lvl_dec];
               ram_wr_data = low_bit ? {chain_link, LINK_W'(0)} : {LINK_W'(0), chain_link};
            end
            count_in = count_ff + 1'b1;
            if (lvl_ff == '0) begin
               prefix_in  = prefix_ff ^ val_ff;
               lvl_in     = LVL_W'(KEY_BITS - 1);
               at_root_in = 1'b1;
               acc_in     = '0;
               state_in   = ST_QRY;
            end else begin
               lvl_in = lvl_dec;
            end
         end

         ST_QRY: begin
            if (step.took_opp) begin
               acc_in = acc_ff | (KEY_BITS'(1) << lvl_ff);
            end
            if (!step.hit || lvl_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               ram_rd_en  = 1'b1;
               at_root_in = 1'b0;
               lvl_in     = lvl_dec;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               best_in      = best_new;
               rsp_best_in  = best_wide[OUT_W-1:0];
               rsp_full_in  = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         at_root_ff   <= 1'b1;
         root_zero_ff <= '0;
         root_one_ff  <= '0;
         count_ff     <= CNT_W'(1);
         prefix_ff    <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         at_root_ff   <= at_root_in;
         root_zero_ff <= root_zero_in;
         root_one_ff  <= root_one_in;
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff      <= lvl_in;
      node_ff     <= node_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      rsp_best_ff <= rsp_best_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_xor   = rsp_best_ff;
   assign rsp_store_full = rsp_full_ff;

   // node count never passes the store size
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NODE_SLOTS))
      else $error("node count beyond store size");

   // the root is kept in flops and is never written to the ram
   a_no_root_write : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ram_wr_addr != '0)
      else $error("ram write to root node");

   // writes only touch nodes already allocated or the one being allocated
   a_write_in_use : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> CNT_W'(ram_wr_addr) <= count_ff)
      else $error("ram write beyond allocated nodes");

   // an accepted transaction always starts with the insert walk
   a_accept_insert : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_INS && at_root_ff))
      else $error("accepted transaction did not start insert");

   // only the first query level reads the root
   a_query_root : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY && !at_root_ff) |-> lvl_ff != LVL_W'(KEY_BITS - 1))
      else $error("query left root at top level");

endmodule

// File: dv/tb_max_xor_subarray_trie_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_xor_subarray_trie_core
// self-checking regression for the maximum subarray xor trie core
// ----------------------------------------------------------------------------
// a queue of stream words feeds a clocked driver with random gaps; a clocked
// monitor under random back pressure compares every result with a trie
// model updated at each accepted request. stimulus covers directed corner
// values and random sequences.
// ----------------------------------------------------------------------------
module tb_max_xor_subarray_trie_core;
   import mxt_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int RANDOM_WORDS = 1000;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 128;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               start_new;
   } stream_word_type;

   typedef struct {
      logic [OUT_W-1:0] best_xor;
      logic             store_full;
   } run_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic               req_start_new = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [OUT_W-1:0]   rsp_best_xor;
   logic               rsp_store_full;

   max_xor_subarray_trie_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_start_new  (req_start_new),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_xor   (rsp_best_xor),
      .rsp_store_full (rsp_store_full)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // trie model state, every link starts empty
   bit [LINK_W-1:0]     trie_links [NODE_SLOTS][2];
   int unsigned         nodes_used = 1;
   logic [KEY_BITS-1:0] run_prefix = '0;
   logic [KEY_BITS-1:0] best_run = '0;
   bit                  store_was_full = 1'b0;

   stream_word_type pending_words[$];
   run_result_type  run_results[$];

   // handshake bookkeeping
   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;
   bit req_busy = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   int faults = 0;
   int words_taken = 0;
   int results_checked = 0;
   int full_results = 0;
   int sequences = 0;

   // walk the prefix into the trie, skipping the whole insert if it cannot fit
   function automatic void trie_store_prefix(input logic [KEY_BITS-1:0] key);
      int unsigned node;
      int unsigned need;
      int unsigned nxt;
      node = 0;
      need = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (trie_links[node][key[lvl]] == '0) begin
            need = lvl + 1;
            break;
         end
         node = trie_links[node][key[lvl]];
      end
      if (nodes_used + need > NODE_SLOTS) begin
         store_was_full = 1'b1;
         return;
      end
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = trie_links[node][key[lvl]];
         if (nxt == 0) begin
            nxt = nodes_used;
            nodes_used++;
            trie_links[nxt][0] = '0;
            trie_links[nxt][1] = '0;
            trie_links[node][key[lvl]] = link_type'(nxt);
         end
         node = nxt;
      end
   endfunction

   // greedy walk taking the opposite bit wherever a link exists
   function automatic logic [KEY_BITS-1:0] trie_farthest(input logic [KEY_BITS-1:0] key);
      int unsigned         node;
      logic [KEY_BITS-1:0] acc;
      node = 0;
      acc = '0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         if (trie_links[node][key[lvl] ^ 1'b1] != '0) begin
            acc[lvl] = 1'b1;
            node = trie_links[node][key[lvl] ^ 1'b1];
         end else if (trie_links[node][key[lvl]] != '0) begin
            node = trie_links[node][key[lvl]];
         end else begin
            break;
         end
      end
      return acc;
   endfunction

   function automatic void advance_best_run(input stream_word_type w);
      logic [KEY_BITS-1:0] cand;
      run_result_type      r;
      if (w.start_new) begin
         trie_links[0][0] = '0;
         trie_links[0][1] = '0;
         nodes_used = 1;
         run_prefix = '0;
         best_run = '0;
         store_was_full = 1'b0;
      end
      trie_store_prefix(run_prefix);
      run_prefix = run_prefix ^ w.value[KEY_BITS-1:0];
      cand = trie_farthest(run_prefix);
      if (cand > best_run)
         best_run = cand;
      r.best_xor = OUT_W'(best_run);
      r.store_full = store_was_full;
      run_results.push_back(r);
   endfunction

   // wait length per transaction, with occasional stretches of none at all
   function automatic int pick_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0)
         calm = ~calm;
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return {VALUE_W{1'b1}};
         2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
         3, 4: return VALUE_W'($urandom_range(0, 15));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic void queue_word(input bit start_new, input logic [VALUE_W-1:0] value);
      stream_word_type w;
      w.start_new = start_new;
      w.value = value;
      if (start_new)
         sequences++;
      pending_words.push_back(w);
   endfunction

   task automatic log_fault(input string what);
      if (faults < 10)
         $display("[%0t] %s", $realtime, what);
      faults++;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_busy || run_results.size() != 0)
         @(posedge clock);
   endtask

   // driver: one word per transaction, inputs moved on the falling edge
   always @(negedge clock) begin
      stream_word_type w;
      if (!reset) begin
         if (req_fired) begin
            req_fired = 1'b0;
            req_busy = 1'b0;
            gap_left = pick_wait(req_calm);
         end
         if (!req_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_value <= w.value;
               req_start_new <= w.start_new;
               req_busy = 1'b1;
            end
         end
         req_valid <= req_busy;
      end
   end

   // result side back pressure, counted down while a result is offered
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) begin
            rsp_fired = 1'b0;
            stall_left = pick_wait(rsp_calm);
         end
         rsp_stall <= (stall_left != 0);
         if (rsp_valid && stall_left != 0)
            stall_left--;
      end
   end

   // monitor: model update on request, compare on result
   always @(posedge clock) begin
      run_result_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_fired = 1'b1;
            words_taken++;
            advance_best_run('{value: req_value, start_new: req_start_new});
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_fired = 1'b1;
            if (run_results.size() == 0) begin
               log_fault($sformatf("unexpected result best_xor=%h store_full=%b",
                                   rsp_best_xor, rsp_store_full));
            end else begin
               exp_r = run_results.pop_front();
               results_checked++;
               if (rsp_store_full)
                  full_results++;
               if (rsp_best_xor !== exp_r.best_xor || rsp_store_full !== exp_r.store_full)
                  log_fault($sformatf("result %0d: expected best_xor=%h store_full=%b, got %h %b",
                                      results_checked, exp_r.best_xor, exp_r.store_full,
                                      rsp_best_xor, rsp_store_full));
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("max_xor_subarray_trie_core regression: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int seq_len;
      int queued;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: state straight from reset, extremes, repeated prefixes
      queue_word(1'b0, 31'h0000_1234);
      queue_word(1'b0, 31'h7fff_ffff);
      queue_word(1'b0, 31'h0000_0000);
      queue_word(1'b0, 31'h7fff_ffff);
      queue_word(1'b1, 31'h0000_0000);
      queue_word(1'b0, 31'h4000_0000);
      queue_word(1'b0, 31'h0000_0001);
      queue_word(1'b0, 31'h5555_5555);
      queue_word(1'b0, 31'h2aaa_aaaa);
      queue_word(1'b0, 31'h7fff_ffff);
      queue_word(1'b1, 31'h7fff_ffff);
      queue_word(1'b0, 31'h7fff_ffff);
      queue_word(1'b1, 31'h0000_0005);
      queue_word(1'b0, 31'h0000_0003);
      queue_word(1'b0, 31'h0000_0006);
      queue_word(1'b0, 31'h0000_0005);
      queue_word(1'b1, 31'h4000_0000);
      queue_word(1'b0, 31'h4000_0001);
      queue_word(1'b0, 31'h3fff_ffff);
      queue_word(1'b1, 31'h0000_0001);
      wait_drained();

      // random sequences, each opened with a start
      queued = 0;
      while (queued < RANDOM_WORDS) begin
         seq_len = $urandom_range(1, 40);
         queue_word(1'b1, pick_value());
         for (int i = 1; i < seq_len; i++)
            queue_word($urandom_range(0, 31) == 0, pick_value());
         queued += seq_len;
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results checked over %0d sequences",
               words_taken, results_checked, sequences);
      $display("%0d results carried the store full flag, %0d mismatches",
               full_results, faults);
      if (faults == 0 && run_results.size() == 0)
         $display("max_xor_subarray_trie_core regression: pass");
      else
         $display("max_xor_subarray_trie_core regression: fail");
      $finish;
   end

endmodule

// File: max_xor_subarray_trie_core.f
design/mxt_pkg.sv
design/mxt_ram.sv
design/mxt_step.sv
design/max_xor_subarray_trie_core.sv
dv/tb_max_xor_subarray_trie_core.sv
